@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define VWC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define VWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vwc_pkg.sv @@
// ---------------------------------------------------------------------------
// vwc_pkg
// Types, constants and arithmetic helpers for the wall collision pipeline.
// ---------------------------------------------------------------------------
package vwc_pkg;

  localparam int PosW     = 32;
  localparam int VelW     = 40;
  localparam int RadW     = 31;
  localparam int RestW    = 16;
  localparam int FricW    = 16;
  localparam int FactW    = 21;
  localparam int TsW      = 11;
  localparam int DimW     = 16;
  localparam int ProdAW   = VelW + RestW + 1;
  localparam int ProdOW   = VelW + FactW;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 192;
  localparam int OutDataW = 128;

  localparam logic [DimW-1:0] ArenaWidthRst  = 16'd1792;
  localparam logic [DimW-1:0] ArenaHeightRst = 16'd960;
  localparam logic [TsW-1:0]  TimeStepRst    = 11'd1311;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [VelW-1:0]  vel_t;
  typedef logic signed [FactW-1:0] fact_t;

  localparam vel_t VelMax    = 40'sh7F_FFFF_FFFF;
  localparam vel_t VelMinRaw = 40'sh80_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegArenaWidth  = 2'd0,
    RegArenaHeight = 2'd1,
    RegTimeStep    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [TsW-1:0]  time_step;
  } cfg_t;

  // Input payload, last field in the lowest bits
  typedef struct packed {
    logic [FricW-1:0] friction;
    logic [RestW-1:0] restitution;
    logic [RadW-1:0]  radius;
    pos_t             prev_y;
    pos_t             prev_x;
    pos_t             pos_y;
    pos_t             pos_x;
  } in_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    pos_t new_prev_y;
    pos_t new_prev_x;
    pos_t new_pos_y;
    pos_t new_pos_x;
  } out_t;

  // Particle state carried between pipeline stages
  typedef struct packed {
    pos_t             pos_x;
    pos_t             pos_y;
    vel_t             vel_x;
    vel_t             vel_y;
    logic             hit_x;
    logic             hit_y;
    logic [RestW-1:0] rest;
    fact_t            fact;
  } item_t;

  typedef struct packed {
    logic hit;
    pos_t pos;
  } clamp_t;

  // Exchange the roles of the two axes
  function automatic item_t swap_axes(input item_t it);
    item_t r;
    r       = it;
    r.pos_x = it.pos_y;
    r.pos_y = it.pos_x;
    r.vel_x = it.vel_y;
    r.vel_y = it.vel_x;
    r.hit_x = it.hit_y;
    r.hit_y = it.hit_x;
    return r;
  endfunction

  // Clamp one coordinate against the walls at 0 and at wall
  function automatic clamp_t clamp_axis(input pos_t pos, input logic [RadW-1:0] rad,
                                        input logic [DimW-1:0] wall);
    logic signed [PosW+1:0] p;
    logic signed [PosW+1:0] r;
    logic signed [PosW+1:0] w;
    logic signed [PosW+1:0] lo;
    logic signed [PosW+1:0] hi;
    logic signed [PosW+1:0] wr;
    clamp_t res;
    p  = (PosW+2)'(pos);
    r  = $signed({3'b000, rad});
    w  = $signed({2'b00, wall, 16'h0000});
    lo = p - r;
    hi = p + r;
    wr = w - r;
    res.hit = 1'b1;
    if (lo < 0) begin
      res.pos = $signed({1'b0, rad});
    end else if (hi > w) begin
      res.pos = (wr > 34'sd2147483647) ? 32'sh7FFF_FFFF : wr[PosW-1:0];
    end else begin
      res.hit = 1'b0;
      res.pos = pos;
    end
    return res;
  endfunction

  // Arithmetic shift right, rounding toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] p,
                                                   input logic [4:0] s);
    logic signed [63:0] bias;
    bias = p[63] ? ((64'sd1 <<< s) - 64'sd1) : 64'sd0;
    return (p + bias) >>> s;
  endfunction

  // Symmetric saturation to the velocity range
  function automatic vel_t sat_vel(input logic signed [63:0] v);
    vel_t r;
    if (v > 64'(VelMax)) begin
      r = VelMax;
    end else if (v < -64'(VelMax)) begin
      r = -VelMax;
    end else begin
      r = v[VelW-1:0];
    end
    return r;
  endfunction

  // Saturation to the signed 32 bit range
  function automatic pos_t sat_pos(input logic signed [VelW:0] v);
    pos_t r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/vwc_front.sv @@
// ---------------------------------------------------------------------------
// vwc_front
// First stage: velocities, friction factor and wall clamps of both axes.
// ---------------------------------------------------------------------------
module vwc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vwc_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  vwc_pkg::in_t    data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output vwc_pkg::item_t  item_o
);

  logic                       valid_q;
  vwc_pkg::item_t             item_q;
  vwc_pkg::item_t             item_d;
  vwc_pkg::clamp_t            cx;
  vwc_pkg::clamp_t            cy;
  logic [vwc_pkg::FricW+vwc_pkg::TsW-1:0] fts;

  assign ready_o = !valid_q || ready_i;

  // Derive the Verlet velocities, the friction factor and the clamped positions
  always_comb begin
    cx  = vwc_pkg::clamp_axis(data_i.pos_x, data_i.radius, cfg_i.width);
    cy  = vwc_pkg::clamp_axis(data_i.pos_y, data_i.radius, cfg_i.height);
    fts = data_i.friction * cfg_i.time_step;
    item_d.pos_x = cx.pos;
    item_d.pos_y = cy.pos;
    item_d.hit_x = cx.hit;
    item_d.hit_y = cy.hit;
    item_d.vel_x = vwc_pkg::VelW'(data_i.pos_x) - vwc_pkg::VelW'(data_i.prev_x);
    item_d.vel_y = vwc_pkg::VelW'(data_i.pos_y) - vwc_pkg::VelW'(data_i.prev_y);
    item_d.rest  = data_i.restitution;
    item_d.fact  = 21'sd65536 - $signed({2'b00, fts[vwc_pkg::FricW+vwc_pkg::TsW-1:8]});
  end

  // Advance the stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload on a transaction
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/vwc_axis.sv @@
// ---------------------------------------------------------------------------
// vwc_axis
// Two-stage collision response along x: multiply, then round and saturate.
// ---------------------------------------------------------------------------
module vwc_axis (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  vwc_pkg::item_t  item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output vwc_pkg::item_t  item_o
);

  `include "assert_macros.svh"

  logic                                s1_valid_q;
  logic                                s2_valid_q;
  logic                                s2_ready;
  vwc_pkg::item_t                      s1_q;
  vwc_pkg::item_t                      s2_q;
  vwc_pkg::item_t                      s2_d;
  logic signed [vwc_pkg::ProdAW-1:0]   prod_a_d;
  logic signed [vwc_pkg::ProdAW-1:0]   prod_a_q;
  logic signed [vwc_pkg::ProdOW-1:0]   prod_o_d;
  logic signed [vwc_pkg::ProdOW-1:0]   prod_o_q;
  logic signed [63:0]                  q_a;
  logic signed [63:0]                  q_o;

  assign s2_ready = !s2_valid_q || ready_i;
  assign ready_o  = !s1_valid_q || s2_ready;

  // Form the restitution and friction products
  always_comb begin
    prod_a_d = item_i.vel_x * $signed({1'b0, item_i.rest});
    prod_o_d = item_i.vel_y * item_i.fact;
  end

  // On a hit, scale back, reflect the normal velocity, apply friction to the tangential one and saturate
  always_comb begin
    q_a  = vwc_pkg::trunc_shr(64'(prod_a_q), 5'd8);
    q_o  = vwc_pkg::trunc_shr(64'(prod_o_q), 5'd16);
    s2_d = s1_q;
    if (s1_q.hit_x) begin
      s2_d.vel_x = vwc_pkg::sat_vel(-q_a);
      s2_d.vel_y = vwc_pkg::sat_vel(q_o);
    end
  end

  // Advance the valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s1_q     <= item_i;
      prod_a_q <= prod_a_d;
      prod_o_q <= prod_o_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_q;

  `VWC_ASSERT_NEXT(a_hold_stalled, s2_valid_q && !ready_i, s2_valid_q && $stable(s2_q),
    "axis stage lost or changed a stalled transaction")
  `VWC_ASSERT(a_vel_symmetric, s2_valid_q,
    (s2_q.vel_x != vwc_pkg::VelMinRaw) && (s2_q.vel_y != vwc_pkg::VelMinRaw),
    "velocity left the symmetric saturation range")

endmodule

@@ rtl/vwc_out.sv @@
// ---------------------------------------------------------------------------
// vwc_out
// Last stage: previous positions from the final velocities, output register.
// ---------------------------------------------------------------------------
module vwc_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  vwc_pkg::item_t  item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output vwc_pkg::out_t   data_o
);

  `include "assert_macros.svh"

  logic                            valid_q;
  vwc_pkg::out_t                   data_q;
  vwc_pkg::out_t                   data_d;
  logic signed [vwc_pkg::VelW:0]   dx;
  logic signed [vwc_pkg::VelW:0]   dy;

  assign ready_o = !valid_q || ready_i;

  // Step back by the velocity and saturate
  always_comb begin
    dx = (vwc_pkg::VelW+1)'(item_i.pos_x) - (vwc_pkg::VelW+1)'(item_i.vel_x);
    dy = (vwc_pkg::VelW+1)'(item_i.pos_y) - (vwc_pkg::VelW+1)'(item_i.vel_y);
    data_d.new_pos_x  = item_i.pos_x;
    data_d.new_pos_y  = item_i.pos_y;
    data_d.new_prev_x = vwc_pkg::sat_pos(dx);
    data_d.new_prev_y = vwc_pkg::sat_pos(dy);
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `VWC_ASSERT(a_rise_from_input, $rose(valid_q), $past(valid_i),
    "result appeared without an upstream transaction")

endmodule

@@ rtl/verlet_wall_collision.sv @@
// ---------------------------------------------------------------------------
// verlet_wall_collision
// Wall collision response for Verlet particles in a rectangular arena.
// ---------------------------------------------------------------------------
// Takes one particle per clock unless back pressure stalls the input, and
// returns one result per particle, in order. A particle passes six register
// stages: one for the clamps and the friction factor, two for each axis (a
// product register, then round and saturate) and the output register, which
// presents its result on m_axis_tvalid. Throughput is one particle per
// cycle while the output is not stalled, set by the per-axis multiplier
// pairs, which are fully pipelined; back pressure stalls only stages that
// hold data, so bubbles are squeezed out. Configuration writes are taken
// at any time with cfg_ready_o tied high and must only be issued while no
// particle is in flight.
module verlet_wall_collision (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vwc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vwc_pkg::CfgDataW-1:0]    cfg_data_i,
  // Particle input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x[31:0], pos_y[63:32], prev_x[95:64], prev_y[127:96], radius[158:128],
  // restitution[174:159], friction[190:175], zero[191]
  input  logic [vwc_pkg::InDataW-1:0]     s_axis_tdata,
  // Result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // new_pos_x[31:0], new_pos_y[63:32], new_prev_x[95:64], new_prev_y[127:96]
  output logic [vwc_pkg::OutDataW-1:0]    m_axis_tdata
);

  `include "assert_macros.svh"

  vwc_pkg::cfg_t   cfg_q;
  vwc_pkg::in_t    in_data;
  vwc_pkg::item_t  front_item;
  vwc_pkg::item_t  ax_item;
  vwc_pkg::item_t  ay_item;
  vwc_pkg::out_t   out_data;
  logic            front_valid;
  logic            front_ready;
  logic            ax_valid;
  logic            ax_ready;
  logic            ay_valid;
  logic            ay_ready;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= vwc_pkg::ArenaWidthRst;
      cfg_q.height    <= vwc_pkg::ArenaHeightRst;
      cfg_q.time_step <= vwc_pkg::TimeStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vwc_pkg::RegArenaWidth:  cfg_q.width     <= cfg_data_i;
        vwc_pkg::RegArenaHeight: cfg_q.height    <= cfg_data_i;
        vwc_pkg::RegTimeStep:    cfg_q.time_step <= cfg_data_i[vwc_pkg::TsW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_data = vwc_pkg::in_t'(s_axis_tdata[vwc_pkg::InDataW-2:0]);

  vwc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_data),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .item_o  (front_item)
  );

  // Resolve the x axis
  vwc_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .item_i  (front_item),
    .valid_o (ax_valid),
    .ready_i (ax_ready),
    .item_o  (ax_item)
  );

  // Resolve the y axis on a second instance of the unit with the axes exchanged
  vwc_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ax_valid),
    .ready_o (ax_ready),
    .item_i  (vwc_pkg::swap_axes(ax_item)),
    .valid_o (ay_valid),
    .ready_i (ay_ready),
    .item_o  (ay_item)
  );

  vwc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ay_valid),
    .ready_o (ay_ready),
    .item_i  (vwc_pkg::swap_axes(ay_item)),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  assign m_axis_tdata = out_data;

  `VWC_ASSERT(a_empty_out_ready, !m_axis_tvalid, s_axis_tready,
    "input stalled while the output register is empty")

endmodule

@@ dv/tb_verlet_wall_collision.sv @@
// ---------------------------------------------------------------------------
// tb_verlet_wall_collision
// Self-checking testbench for the Verlet wall collision pipeline.
// ---------------------------------------------------------------------------
// Streams particles into the block and compares every result with a software
// predictor. Directed particles cover the wall edges, the field extremes,
// saturation of the velocity and of the new previous position, and a
// negative friction factor. Random particles are mostly placed against the
// walls. The arena is reprogrammed between batches: zero size, full size,
// a time step above its cap, and random settings. Both stream sides stall
// at random, apart from one batch that runs at full rate.
// ---------------------------------------------------------------------------
module tb_verlet_wall_collision
  import vwc_pkg::*;
();

  localparam int  HalfPeriod = 4;
  localparam int  ResetCycles = 8;
  localparam int  StallLimit = 4000;
  localparam int  BatchSize = 275;
  localparam int  U = 65536;

  // Predicts one result per particle and checks results in order
  class collision_scoreboard;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [TsW-1:0]  tstep;
    out_t            pending_q[$];
    int              errors;
    int              particles;
    int              results;
    int              contacts;

    function new();
      width  = ArenaWidthRst;
      height = ArenaHeightRst;
      tstep  = TimeStepRst;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegArenaWidth:  width = val;
        RegArenaHeight: height = val;
        RegTimeStep:    tstep = val[TsW-1:0];
        default: ;
      endcase
    endfunction

    // Product scaled down by 2^sh, truncated toward zero
    function longint scale_trunc(longint a, longint b, int sh);
      longint p;
      p = a * b;
      if (p < 0) return -((-p) >>> sh);
      return p >>> sh;
    endfunction

    function longint clip_vel(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813887) return -64'sd549755813887;
      return v;
    endfunction

    function pos_t clip_pos(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Clamp one axis against its walls; on contact reflect the normal
    // velocity and apply friction to the tangential one
    function bit resolve_axis(inout longint pos, inout longint vel, inout longint other,
                              input longint rad, input longint wall,
                              input longint rest, input longint fact);
      bit hit;
      hit = 1'b0;
      if (pos - rad < 0) begin
        pos = rad;
        hit = 1'b1;
      end else if (pos + rad > wall) begin
        pos = clip_pos(wall - rad);
        hit = 1'b1;
      end
      if (hit) begin
        vel   = clip_vel(scale_trunc(-vel, rest, 8));
        other = clip_vel(scale_trunc(other, fact, 16));
      end
      return hit;
    endfunction

    function out_t predict_bounce(in_t p);
      longint px, py, vx, vy, rad, rest, fprod, fact, wx, wy;
      out_t   r;
      px    = longint'(p.pos_x);
      py    = longint'(p.pos_y);
      vx    = px - longint'(p.prev_x);
      vy    = py - longint'(p.prev_y);
      rad   = longint'(p.radius);
      rest  = longint'(p.restitution);
      fprod = longint'(p.friction);
      fprod = fprod * longint'(tstep);
      fact  = 64'sd65536 - (fprod >>> 8);
      wx    = longint'(width);
      wx    = wx <<< 16;
      wy    = longint'(height);
      wy    = wy <<< 16;
      contacts += int'(resolve_axis(px, vx, vy, rad, wx, rest, fact));
      contacts += int'(resolve_axis(py, vy, vx, rad, wy, rest, fact));
      r.new_pos_x  = px[31:0];
      r.new_pos_y  = py[31:0];
      r.new_prev_x = clip_pos(px - vx);
      r.new_prev_y = clip_pos(py - vy);
      return r;
    endfunction

    function void note_particle(in_t p);
      particles++;
      pending_q.push_back(predict_bounce(p));
    endfunction

    function void compare_field(string name, pos_t want, pos_t got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $error("result with no particle outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      results++;
      compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
      compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
      compare_field("new_prev_x", want.new_prev_x, got.new_prev_x);
      compare_field("new_prev_y", want.new_prev_y, got.new_prev_y);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic                steady = 1'b0;
  int                  stall_cycles = 0;
  int                  settings = 1;
  collision_scoreboard sb = new();

  verlet_wall_collision i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Check each result transaction and stall the result side at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_verlet_wall_collision NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_t particle(logic [31:0] px, logic [31:0] py, logic [31:0] ox,
                                   logic [31:0] oy, logic [31:0] rad,
                                   logic [RestW-1:0] rest, logic [FricW-1:0] fric);
    in_t p;
    p.pos_x       = px;
    p.pos_y       = py;
    p.prev_x      = ox;
    p.prev_y      = oy;
    p.radius      = rad[RadW-1:0];
    p.restitution = rest;
    p.friction    = fric;
    return p;
  endfunction

  // Pick a coordinate along one axis, mostly close to a wall
  function automatic pos_t axis_coord(longint wall, longint rad);
    longint c;
    longint off;
    off = longint'($urandom_range(0, 8 * U)) - 4 * U;
    case ($urandom_range(0, 5))
      0: c = rad + off;
      1: c = wall - rad + off;
      2: c = longint'($urandom) % (wall + 1);
      3: c = -longint'($urandom_range(0, 64 * U));
      4: c = wall + longint'($urandom_range(0, 64 * U));
      default: c = longint'($signed($urandom));
    endcase
    return c[31:0];
  endfunction

  function automatic in_t random_particle();
    in_t    p;
    longint rad, vx, vy, wx, wy;
    // Raw noise over every bit of every field
    if ($urandom_range(0, 9) == 0) begin
      p.pos_x       = $urandom;
      p.pos_y       = $urandom;
      p.prev_x      = $urandom;
      p.prev_y      = $urandom;
      p.radius      = RadW'($urandom);
      p.restitution = RestW'($urandom);
      p.friction    = FricW'($urandom);
      return p;
    end
    rad = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 32'h7FFF_FFFF))
                                      : longint'($urandom_range(0, 64 * U));
    wx  = longint'(sb.width);
    wx  = wx <<< 16;
    wy  = longint'(sb.height);
    wy  = wy <<< 16;
    vx  = ($urandom_range(0, 7) == 0) ? longint'($signed($urandom))
                                      : longint'($urandom_range(0, 4 * U)) - 2 * U;
    vy  = ($urandom_range(0, 7) == 0) ? longint'($signed($urandom))
                                      : longint'($urandom_range(0, 4 * U)) - 2 * U;
    p.pos_x       = axis_coord(wx, rad);
    p.pos_y       = axis_coord(wy, rad);
    p.prev_x      = p.pos_x - pos_t'(vx);
    p.prev_y      = p.pos_y - pos_t'(vy);
    p.radius      = rad[RadW-1:0];
    p.restitution = RestW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 320));
    p.friction    = FricW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2048));
    return p;
  endfunction

  // Present one particle, idling first at random, and hold until accepted
  task automatic send_particle(input in_t p);
    while (!steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_particle(p);
  endtask

  task automatic stream_particles(input int count);
    repeat (count) send_particle(random_particle());
    s_axis_tvalid <= 1'b0;
  endtask

  // Let the pipeline drain completely
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Reprogram the arena once the block is idle
  task automatic program_arena(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                               input logic [CfgDataW-1:0] ts);
    drain();
    write_reg(RegArenaWidth, w);
    write_reg(RegArenaHeight, h);
    write_reg(RegTimeStep, ts);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Directed particles for the reset arena of 1792 by 960
  task automatic run_directed();
    send_particle(particle(100 * U, 100 * U, 99 * U, 101 * U, 10 * U, 16'h00CC, 16'h0080));
    send_particle(particle(5 * U, 300 * U, 8 * U, 298 * U, 10 * U, 16'h00CC, 16'h0100));
    send_particle(particle(1790 * U, 300 * U, 1785 * U, 301 * U, 10 * U, 16'h0100, 16'h0200));
    send_particle(particle(500 * U, 3 * U, 502 * U, 9 * U, 8 * U, 16'h0080, 16'h0100));
    send_particle(particle(500 * U, 958 * U, 499 * U, 950 * U, 8 * U, 16'h00E0, 16'h0040));
    send_particle(particle(2 * U, 959 * U, 6 * U, 953 * U, 4 * U, 16'h00C0, 16'h0300));
    // Field extremes
    send_particle(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           '0, '0, '0));
    send_particle(particle('0, '0, '0, '0, '0, '0, '0));
    // Touching a wall exactly is no contact, one step further is
    send_particle(particle(10 * U, 950 * U, 9 * U, 951 * U, 10 * U, 16'h00C0, 16'h0100));
    send_particle(particle(10 * U - 1, 950 * U + 1, 9 * U, 951 * U, 10 * U, 16'h00C0, 16'h0100));
    // New previous position saturates after a strong bounce
    send_particle(particle(5 * U, 300 * U, 5 * U + 32'h4000_0000, 300 * U, 10 * U,
                           16'hFFFF, 16'h0000));
    // Friction factor below zero on a fast tangential velocity
    send_particle(particle(1795 * U, 300 * U, 1794 * U, 200 * U, U, 16'h0100, 16'hFFFF));
    // Huge radius in the middle, negative position, zero radius past a corner
    send_particle(particle(900 * U, 480 * U, 901 * U, 479 * U, 32'h7FFF_FFFF, 16'h0100,
                           16'h0100));
    send_particle(particle(-100 * U, 480 * U, -90 * U, 470 * U, 2 * U, 16'h00F0, 16'h0080));
    send_particle(particle(1792 * U + 1, 960 * U + 1, 1790 * U, 955 * U, '0, 16'h0100,
                           16'h0100));
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    stream_particles(BatchSize);

    // Empty arena, no friction
    program_arena(16'd0, 16'd0, 16'd0);
    stream_particles(BatchSize);

    // Largest arena, time step far above its cap, both sides at full rate
    program_arena(16'hFFFF, 16'hFFFF, 16'd2047);
    steady <= 1'b1;
    stream_particles(BatchSize);
    steady <= 1'b0;

    // Narrow strip, time step just above its cap
    program_arena(16'd1, 16'hFFFF, 16'd1312);
    stream_particles(BatchSize);

    program_arena(CfgDataW'($urandom_range(0, 65535)), CfgDataW'($urandom_range(0, 65535)),
                  CfgDataW'($urandom_range(0, 2047)));
    stream_particles(BatchSize);

    program_arena(16'd640, 16'd480, 16'd1311);
    stream_particles(BatchSize);

    drain();
    $display("Checked %0d of %0d particles over %0d arena settings.",
             sb.results, sb.particles, settings);
    $display("Predicted %0d wall contacts; %0d mismatches.", sb.contacts, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_verlet_wall_collision OK");
    end else begin
      $display("tb_verlet_wall_collision NOT OK");
    end
    $finish;
  end

endmodule
